FILE: rtl/owi_pkg.sv
// owi_pkg: shared types and constants of the one-wire frame transmitter
// request and result structs, configuration struct, phase codes and register indexes
// no dependencies
package owi_pkg;

	localparam int CFG_W       = 16;
	localparam int CFG_IDX_W   = 2;
	localparam int FRAME_BITS  = 43;
	localparam int PREFIX_BITS = 11;

	localparam logic [CFG_IDX_W-1:0] CFG_SHORT_PHASE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LONG_PHASE  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_START_LOW   = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_STOP_SPAN   = 2'd3;

	localparam logic [CFG_W-1:0] RST_SHORT_PHASE = 16'd24;
	localparam logic [CFG_W-1:0] RST_LONG_PHASE  = 16'd72;
	localparam logic [CFG_W-1:0] RST_START_LOW   = 16'd120;
	localparam logic [CFG_W-1:0] RST_STOP_SPAN   = 16'd96;

	localparam logic [2:0] PH_IDLE  = 3'd0;
	localparam logic [2:0] PH_START = 3'd1;
	localparam logic [2:0] PH_HIGH  = 3'd2;
	localparam logic [2:0] PH_LOW   = 3'd3;
	localparam logic [2:0] PH_STOP  = 3'd4;

	localparam logic MODE_TICK = 1'b0;
	localparam logic MODE_LOAD = 1'b1;

	typedef struct packed {
		logic       mode;
		logic [7:0] reg_address;
		logic       read_request;
		logic [2:0] byte_count;
		logic [7:0] payload_0;
		logic [7:0] payload_1;
		logic [7:0] payload_2;
		logic [7:0] payload_3;
	} owi_in_t;

	typedef struct packed {
		logic line_level;
		logic busy_res;
		logic frame_done;
		logic command_error;
	} owi_out_t;

	typedef struct packed {
		logic [CFG_W-1:0] short_phase;
		logic [CFG_W-1:0] long_phase;
		logic [CFG_W-1:0] start_low;
		logic [CFG_W-1:0] stop_span;
	} owi_cfg_t;

endpackage

FILE: rtl/owi_cfg_regs.sv
// owi_cfg_regs: timing configuration registers of the frame transmitter
// written through a plain write port, no read-back
// depends on owi_pkg
module owi_cfg_regs
	import owi_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_wdata,
	output owi_cfg_t             cfg
);

	owi_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.short_phase <= RST_SHORT_PHASE;
			cfg_q.long_phase  <= RST_LONG_PHASE;
			cfg_q.start_low   <= RST_START_LOW;
			cfg_q.stop_span   <= RST_STOP_SPAN;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_SHORT_PHASE: cfg_q.short_phase <= cfg_wdata;
				CFG_LONG_PHASE:  cfg_q.long_phase  <= cfg_wdata;
				CFG_START_LOW:   cfg_q.start_low   <= cfg_wdata;
				CFG_STOP_SPAN:   cfg_q.stop_span   <= cfg_wdata;
				default:         cfg_q <= cfg_q;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

FILE: rtl/owi_frame_engine.sv
// owi_frame_engine: frame state, bit timers and shift register
// computes one result per request and updates its state when step is high
// depends on owi_pkg
module owi_frame_engine
	import owi_pkg::*;
#(
	parameter int MAX_BYTES  = 4,
	parameter int TIMER_BITS = 16
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     step,
	input  owi_in_t  item,
	input  owi_cfg_t cfg,
	output owi_out_t res
);

	localparam int SW  = PREFIX_BITS + 8 * MAX_BYTES;
	localparam int BLW = $clog2(SW + 1);
	localparam int CW  = (TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W;
	localparam logic [CW-1:0] TMAX_W = CW'((64'd1 << TIMER_BITS) - 64'd1);
	localparam logic [TIMER_BITS-1:0] TMAX = {TIMER_BITS{1'b1}};

	logic [2:0]            ph_q, ph_d;
	logic [SW-1:0]         shift_q, shift_d;
	logic [BLW-1:0]        bits_left_q, bits_left_d;
	logic [TIMER_BITS-1:0] timer_q, timer_d;
	logic [TIMER_BITS-1:0] elapsed_q, elapsed_d;
	logic                  stop_wanted_q, stop_wanted_d;

	logic [TIMER_BITS-1:0] d_short, d_long, d_start, d_span;
	logic [TIMER_BITS-1:0] d_high, d_low, timer_inc, elapsed_inc;
	logic [FRAME_BITS-1:0] frame_full;
	logic [BLW-1:0]        bits_dec;
	logic [6:0]            bl_load;
	logic                  cur_bit, bad_count, level, done, err;

	function automatic logic [TIMER_BITS-1:0] clip(input logic [CFG_W-1:0] v);
		logic [CW-1:0] vw;
		vw = CW'(v);
		if (vw > TMAX_W)
			vw = TMAX_W;
		return vw[TIMER_BITS-1:0];
	endfunction

	assign d_short = clip(cfg.short_phase);
	assign d_long  = clip(cfg.long_phase);
	assign d_start = clip(cfg.start_low);
	assign d_span  = clip(cfg.stop_span);

	assign cur_bit     = shift_q[SW-1];
	assign d_high      = cur_bit ? d_long : d_short;
	assign d_low       = cur_bit ? d_short : d_long;
	assign timer_inc   = (timer_q != TMAX) ? timer_q + 1'b1 : timer_q;
	assign elapsed_inc = (elapsed_q != TMAX) ? elapsed_q + 1'b1 : elapsed_q;
	assign bits_dec    = (bits_left_q != '0) ? bits_left_q - 1'b1 : bits_left_q;

	assign frame_full = {item.reg_address, 2'(item.byte_count - 3'd1), item.read_request,
		item.payload_0, item.payload_1, item.payload_2, item.payload_3};
	assign bl_load   = 7'(PREFIX_BITS) + {1'b0, item.byte_count, 3'b000};
	assign bad_count = (item.byte_count == 3'd0) || (32'(item.byte_count) > MAX_BYTES);

	always_comb begin
		ph_d          = ph_q;
		shift_d       = shift_q;
		bits_left_d   = bits_left_q;
		timer_d       = timer_q;
		elapsed_d     = elapsed_q;
		stop_wanted_d = stop_wanted_q;
		done          = 1'b0;
		err           = 1'b0;
		if (item.mode == MODE_LOAD) begin
			if (ph_q != PH_IDLE || bad_count) begin
				err = 1'b1;
			end else begin
				shift_d       = frame_full[FRAME_BITS-1 -: SW];
				stop_wanted_d = !item.read_request;
				bits_left_d   = item.read_request ? BLW'(PREFIX_BITS) : BLW'(bl_load);
				timer_d       = '0;
				elapsed_d     = '0;
				ph_d          = PH_START;
			end
		end else begin
			case (ph_q)
				PH_START: begin
					timer_d = timer_inc;
					if (timer_inc >= d_start) begin
						timer_d = '0;
						ph_d    = PH_HIGH;
					end
				end
				PH_HIGH: begin
					timer_d = timer_inc;
					if (timer_inc >= d_high) begin
						timer_d   = '0;
						elapsed_d = '0;
						ph_d      = PH_LOW;
					end
				end
				PH_LOW: begin
					timer_d   = timer_inc;
					elapsed_d = elapsed_inc;
					if (timer_inc >= d_low) begin
						timer_d     = '0;
						shift_d     = {shift_q[SW-2:0], 1'b0};
						bits_left_d = bits_dec;
						if (bits_dec != '0) begin
							ph_d = PH_HIGH;
						end else if (stop_wanted_q && elapsed_inc < d_span) begin
							ph_d = PH_STOP;
						end else begin
							ph_d = PH_IDLE;
							done = 1'b1;
						end
					end
				end
				PH_STOP: begin
					elapsed_d = elapsed_inc;
					if (elapsed_inc >= d_span) begin
						ph_d = PH_IDLE;
						done = 1'b1;
					end
				end
				default: ph_d = PH_IDLE;
			endcase
		end
	end

	// line level: after a load, before a tick
	always_comb begin
		if (item.mode == MODE_LOAD)
			level = !(ph_d == PH_START || ph_d == PH_LOW);
		else
			level = !(ph_q == PH_START || ph_q == PH_LOW);
	end

	assign res.line_level    = level;
	assign res.busy_res      = (ph_d != PH_IDLE);
	assign res.frame_done    = done;
	assign res.command_error = err;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q          <= PH_IDLE;
			shift_q       <= '0;
			bits_left_q   <= '0;
			timer_q       <= '0;
			elapsed_q     <= '0;
			stop_wanted_q <= 1'b0;
		end else if (step) begin
			ph_q          <= ph_d;
			shift_q       <= shift_d;
			bits_left_q   <= bits_left_d;
			timer_q       <= timer_d;
			elapsed_q     <= elapsed_d;
			stop_wanted_q <= stop_wanted_d;
		end
	end

	a_bits_while_sending: assert property (@(posedge clk) disable iff (!arst_n)
		(ph_q == PH_HIGH || ph_q == PH_LOW) |-> bits_left_q != '0)
		else $error("bit phase with no bits left");

	a_stop_only_write: assert property (@(posedge clk) disable iff (!arst_n)
		ph_q == PH_STOP |-> stop_wanted_q)
		else $error("stop phase in a read frame");

	a_done_goes_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(step && res.frame_done) |=> ph_q == PH_IDLE)
		else $error("frame done but not idle");

	a_reject_keeps_state: assert property (@(posedge clk) disable iff (!arst_n)
		(step && res.command_error) |=> ($stable(ph_q) && $stable(shift_q)))
		else $error("rejected load changed the frame");

endmodule

FILE: rtl/owi_pwm_frame_transmitter.sv
// owi_pwm_frame_transmitter: top level of the one-wire pwm frame transmitter
// input register, frame engine, configuration registers and result register
// depends on owi_pkg, owi_cfg_regs, owi_frame_engine
//
// Each request is either one time tick or a frame load, and each gives one
// result: the line level driven during that tick, busy, frame done and
// command error. A request is registered, handled combinationally by the
// frame engine and its result is held in an output register, so the block
// takes one request per cycle while the output is not stalled; the rate
// rests on the combinational timer compare and shift of the frame engine. A
// stalled output stops the input side only once the input register is also
// full. Short, long and start-low phases of zero last one tick; the timers
// are TIMER_BITS wide and longer durations are clipped to the timer maximum.
module owi_pwm_frame_transmitter
	import owi_pkg::*;
#(
	parameter int MAX_BYTES  = 4,
	parameter int TIMER_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  owi_in_t              in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output owi_out_t             out_data,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_wdata
);

	owi_cfg_t cfg;
	owi_in_t  in_s1;
	owi_out_t res, out_q;
	logic     in_valid_s1, out_valid_q, advance;

	owi_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	owi_frame_engine #(
		.MAX_BYTES  (MAX_BYTES),
		.TIMER_BITS (TIMER_BITS)
	) u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.item   (in_s1),
		.cfg    (cfg),
		.res    (res)
	);

	assign advance  = in_valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !in_valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_valid && in_ready)
				in_valid_s1 <= 1'b1;
			else if (advance)
				in_valid_s1 <= 1'b0;
			if (advance)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready)
			in_s1 <= in_data;
		if (advance)
			out_q <= res;
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_no_lost_result: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |=> (out_valid_q && $stable(out_q)))
		else $error("pending result dropped or changed");

	a_stall_holds_request: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid_s1 && !advance) |=> (in_valid_s1 && $stable(in_s1)))
		else $error("waiting request lost");

	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		advance |-> !(res.frame_done && res.busy_res))
		else $error("frame done while still busy");

endmodule

FILE: verif/owi_pwm_frame_transmitter_test.sv
// owi_pwm_frame_transmitter_test: self-checking testbench of the one-wire frame transmitter
// drives tick and load requests, predicts each line result and checks it field by field
// depends on owi_pkg and owi_pwm_frame_transmitter
module owi_pwm_frame_transmitter_test;
	import owi_pkg::*;

	localparam int MAX_BYTES  = 4;
	localparam int IDLE_PCT   = 27;
	localparam int QUIET_MAX  = 2000;
	localparam int RAND_ITEMS = 1550;
	localparam logic [CFG_W-1:0] TICK_MAX = '1;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	owi_in_t              in_data = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	owi_out_t             out_data;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = CFG_SHORT_PHASE;
	logic [CFG_W-1:0]     cfg_wdata = '0;

	owi_pwm_frame_transmitter dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// line model state
	owi_cfg_t             line_cfg = '{RST_SHORT_PHASE, RST_LONG_PHASE, RST_START_LOW,
		RST_STOP_SPAN};
	logic [2:0]           frame_phase = PH_IDLE;
	logic [FRAME_BITS-1:0] frame_bits = '0;
	logic [5:0]           bits_to_send = '0;
	logic [CFG_W-1:0]     phase_ticks = '0;
	logic [CFG_W-1:0]     stop_ticks = '0;
	logic                 stop_due = 1'b0;

	owi_out_t line_expect_q[$];
	int       errors = 0;
	int       sent_count = 0;
	int       quiet_cycles = 0;
	bit       gaps_on = 1'b1;

	function automatic logic drive_low(input logic [2:0] ph);
		return ph == PH_START || ph == PH_LOW;
	endfunction

	function automatic owi_out_t step_line_model(input owi_in_t req);
		owi_out_t         res;
		logic [CFG_W-1:0] span;
		logic             bit_one;
		res = '0;
		bit_one = frame_bits[FRAME_BITS-1];
		if (req.mode == MODE_LOAD) begin
			if (frame_phase != PH_IDLE || req.byte_count == 3'd0 ||
					int'(req.byte_count) > MAX_BYTES) begin
				res.command_error = 1'b1;
			end else begin
				frame_bits = {req.reg_address, 2'(req.byte_count - 3'd1), req.read_request,
					req.payload_0, req.payload_1, req.payload_2, req.payload_3};
				stop_due = !req.read_request;
				bits_to_send = req.read_request ? 6'(PREFIX_BITS) :
					6'(PREFIX_BITS + 8 * int'(req.byte_count));
				phase_ticks = '0;
				stop_ticks = '0;
				frame_phase = PH_START;
			end
			res.line_level = !drive_low(frame_phase);
		end else begin
			res.line_level = !drive_low(frame_phase);
			case (frame_phase)
				PH_START: begin
					if (phase_ticks != TICK_MAX) phase_ticks++;
					if (phase_ticks >= line_cfg.start_low) begin
						phase_ticks = '0;
						frame_phase = PH_HIGH;
					end
				end
				PH_HIGH: begin
					span = bit_one ? line_cfg.long_phase : line_cfg.short_phase;
					if (phase_ticks != TICK_MAX) phase_ticks++;
					if (phase_ticks >= span) begin
						phase_ticks = '0;
						stop_ticks = '0;
						frame_phase = PH_LOW;
					end
				end
				PH_LOW: begin
					span = bit_one ? line_cfg.short_phase : line_cfg.long_phase;
					if (phase_ticks != TICK_MAX) phase_ticks++;
					if (stop_ticks != TICK_MAX) stop_ticks++;
					if (phase_ticks >= span) begin
						phase_ticks = '0;
						frame_bits = frame_bits << 1;
						if (bits_to_send != 0) bits_to_send--;
						if (bits_to_send != 0) begin
							frame_phase = PH_HIGH;
						end else if (stop_due && stop_ticks < line_cfg.stop_span) begin
							frame_phase = PH_STOP;
						end else begin
							frame_phase = PH_IDLE;
							res.frame_done = 1'b1;
						end
					end
				end
				PH_STOP: begin
					if (stop_ticks != TICK_MAX) stop_ticks++;
					if (stop_ticks >= line_cfg.stop_span) begin
						frame_phase = PH_IDLE;
						res.frame_done = 1'b1;
					end
				end
				default: begin
					frame_phase = PH_IDLE;
				end
			endcase
		end
		res.busy_res = frame_phase != PH_IDLE;
		return res;
	endfunction

	function automatic owi_in_t rand_req();
		logic [63:0] raw;
		raw = {$urandom, $urandom};
		return owi_in_t'(raw[$bits(owi_in_t)-1:0]);
	endfunction

	function automatic owi_in_t tick_req();
		owi_in_t r;
		r = rand_req();
		r.mode = MODE_TICK;
		return r;
	endfunction

	function automatic owi_in_t load_req(input logic [7:0] addr, input logic rd,
			input logic [2:0] cnt, input logic [31:0] bytes);
		owi_in_t r;
		r.mode = MODE_LOAD;
		r.reg_address = addr;
		r.read_request = rd;
		r.byte_count = cnt;
		{r.payload_0, r.payload_1, r.payload_2, r.payload_3} = bytes;
		return r;
	endfunction

	function automatic owi_in_t rand_load();
		owi_in_t r;
		r = rand_req();
		r.mode = MODE_LOAD;
		r.read_request = $urandom_range(99) < 40;
		if ($urandom_range(99) < 85) r.byte_count = 3'($urandom_range(1, MAX_BYTES));
		return r;
	endfunction

	task automatic send_req(input owi_in_t req);
		while (gaps_on && $urandom_range(99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= req;
		do @(posedge clk); while (!in_ready);
		line_expect_q.push_back(step_line_model(req));
		sent_count++;
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (line_expect_q.size() != 0) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic configure(input logic [CFG_W-1:0] short_ph, input logic [CFG_W-1:0] long_ph,
			input logic [CFG_W-1:0] start_ph, input logic [CFG_W-1:0] stop_ph);
		drain_results();
		cfg_we <= 1'b1;
		cfg_index <= CFG_SHORT_PHASE;
		cfg_wdata <= short_ph;
		@(posedge clk);
		cfg_index <= CFG_LONG_PHASE;
		cfg_wdata <= long_ph;
		@(posedge clk);
		cfg_index <= CFG_START_LOW;
		cfg_wdata <= start_ph;
		@(posedge clk);
		cfg_index <= CFG_STOP_SPAN;
		cfg_wdata <= stop_ph;
		@(posedge clk);
		cfg_we <= 1'b0;
		line_cfg = '{short_ph, long_ph, start_ph, stop_ph};
	endtask

	// ticks until the frame ends; noisy mode mixes in rejected loads and hold-offs
	task automatic finish_frame(input bit noisy);
		while (frame_phase != PH_IDLE) begin
			if (noisy && $urandom_range(999) < 4)
				drain_results();
			if (noisy && $urandom_range(99) < 5)
				send_req(rand_load());
			else
				send_req(tick_req());
		end
	endtask

	task automatic run_frame(input owi_in_t load, input bit noisy);
		send_req(load);
		finish_frame(noisy);
	endtask

	task automatic test_reset_config();
		send_req(load_req(8'hC3, 1'b1, 3'd2, 32'h0));
		repeat (230) send_req(tick_req());
		configure(16'd0, 16'd1, 16'd0, 16'd2);
		finish_frame(1'b0);
	endtask

	task automatic test_bad_loads();
		configure(16'd0, 16'd1, 16'd0, 16'd2);
		send_req(tick_req());
		send_req(load_req(8'h12, 1'b0, 3'd0, 32'h11223344));
		send_req(load_req(8'h34, 1'b1, 3'd5, 32'h0));
		send_req(load_req(8'h56, 1'b0, 3'd6, 32'hFFFFFFFF));
		send_req(load_req(8'h78, 1'b0, 3'd7, 32'h0));
		send_req(tick_req());
	endtask

	task automatic test_write_frames();
		run_frame(load_req(8'hFF, 1'b0, 3'd4, 32'hFF00A55A), 1'b0);
		run_frame(load_req(8'h00, 1'b0, 3'd1, 32'h00FFFFFF), 1'b0);
	endtask

	task automatic test_read_frames();
		run_frame(load_req(8'hFF, 1'b1, 3'd4, 32'hFFFFFFFF), 1'b0);
		run_frame(load_req(8'h00, 1'b1, 3'd1, 32'h0), 1'b0);
	endtask

	task automatic test_busy_load();
		send_req(load_req(8'hA5, 1'b0, 3'd2, 32'h5AA5C33C));
		send_req(tick_req());
		send_req(load_req(8'h3C, 1'b1, 3'd1, 32'h0));
		send_req(tick_req());
		send_req(load_req(8'h0F, 1'b0, 3'd0, 32'h0));
		finish_frame(1'b0);
	endtask

	task automatic test_stop_span();
		configure(16'd2, 16'd3, 16'd1, 16'd0);
		run_frame(load_req(8'h81, 1'b0, 3'd1, 32'h01000000), 1'b0);
		configure(16'd2, 16'd5, 16'd1, 16'd2);
		run_frame(load_req(8'h80, 1'b0, 3'd1, 32'h00000000), 1'b0);
		configure(16'd1, 16'd2, 16'd3, 16'd40);
		run_frame(load_req(8'h7E, 1'b0, 3'd3, 32'h80018001), 1'b0);
	endtask

	task automatic test_zero_phases();
		configure(16'd0, 16'd0, 16'd0, 16'd0);
		run_frame(load_req(8'h96, 1'b0, 3'd2, 32'h6996AAAA), 1'b0);
		run_frame(load_req(8'h69, 1'b1, 3'd3, 32'h0), 1'b0);
	endtask

	task automatic test_timer_limit();
		configure(16'd1, 16'd1, TICK_MAX, 16'd0);
		gaps_on = 1'b0;
		send_req(load_req(8'h5A, 1'b1, 3'd1, 32'h0));
		repeat (100) send_req(tick_req());
		configure(16'd1, 16'd1, 16'd1, TICK_MAX);
		finish_frame(1'b0);
		send_req(load_req(8'hA5, 1'b0, 3'd1, 32'hC3000000));
		while (frame_phase != PH_STOP) send_req(tick_req());
		repeat (100) send_req(tick_req());
		configure(16'd1, 16'd1, 16'd1, 16'd5);
		finish_frame(1'b0);
		gaps_on = 1'b1;
	endtask

	task automatic test_max_phases();
		configure(TICK_MAX, TICK_MAX, 16'd0, TICK_MAX);
		send_req(load_req(8'hF0, 1'b0, 3'd4, 32'h0F0F0F0F));
		repeat (50) send_req(tick_req());
		configure(16'd2, 16'd3, 16'd1, 16'd5);
		finish_frame(1'b0);
	endtask

	task automatic test_random();
		int set_no;
		set_no = 0;
		while (sent_count < RAND_ITEMS) begin
			configure(16'($urandom_range(0, 3)), 16'($urandom_range(0, 5)),
				16'($urandom_range(0, 6)),
				($urandom_range(3) == 0) ? 16'd0 : 16'($urandom_range(1, 40)));
			gaps_on = set_no != 2;
			repeat (4) begin
				if ($urandom_range(9) == 0)
					send_req(tick_req());
				run_frame(rand_load(), 1'b1);
			end
			set_no++;
		end
		gaps_on = 1'b1;
	endtask

	always @(posedge clk) begin
		out_ready <= (gaps_on && $urandom_range(99) < IDLE_PCT) ? 1'b0 : 1'b1;
	end

	function automatic void note_mismatch(input string field, input logic want, input logic got);
		errors++;
		$error("%s: expected %0d, got %0d", field, want, got);
	endfunction

	always @(posedge clk) begin
		owi_out_t want;
		if (arst_n && out_valid && out_ready) begin
			if (line_expect_q.size() == 0) begin
				errors++;
				$error("line result with nothing expected");
			end else begin
				want = line_expect_q.pop_front();
				if (out_data.line_level !== want.line_level)
					note_mismatch("line_level", want.line_level, out_data.line_level);
				if (out_data.busy_res !== want.busy_res)
					note_mismatch("busy_res", want.busy_res, out_data.busy_res);
				if (out_data.frame_done !== want.frame_done)
					note_mismatch("frame_done", want.frame_done, out_data.frame_done);
				if (out_data.command_error !== want.command_error)
					note_mismatch("command_error", want.command_error, out_data.command_error);
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_MAX) begin
			$display("owi_pwm_frame_transmitter_test: FAIL");
			$finish;
		end
	end

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_config();
		test_bad_loads();
		test_write_frames();
		test_read_frames();
		test_busy_load();
		test_stop_span();
		test_zero_phases();
		test_timer_limit();
		test_max_phases();
		test_random();
		drain_results();
		repeat (8) @(posedge clk);
		if (errors == 0)
			$display("owi_pwm_frame_transmitter_test: PASS");
		else
			$display("owi_pwm_frame_transmitter_test: FAIL");
		$finish;
	end

endmodule

FILE: files.f
rtl/owi_pkg.sv
rtl/owi_cfg_regs.sv
rtl/owi_frame_engine.sv
rtl/owi_pwm_frame_transmitter.sv
verif/owi_pwm_frame_transmitter_test.sv
